### src/cem_pkg.sv
// Shared types and constants for the calendar / epoch millisecond converter.
// Used by cem_day_div and calendar_epoch_ms_converter_core; depends on nothing.
package cem_pkg;

  localparam int unsigned MS_PER_DAY  = 86400000;
  localparam int unsigned MS_PER_HOUR = 3600000;
  localparam int unsigned MS_PER_MIN  = 60000;
  localparam int unsigned MS_PER_SEC  = 1000;
  localparam int unsigned DAYS_PER_ERA = 146097;
  localparam int unsigned CIVIL_SHIFT  = 719468;

  // Day divider: the dividend spans the whole year range in ms, the quotient in days.
  localparam int DIV_QW = 20;
  localparam int DIV_RW = 27;
  localparam int DIV_XW = DIV_QW + DIV_RW;

  typedef struct packed {
    logic        mode;
    logic [42:0] ms0;
  } side_t;

  function automatic logic [8:0] days_before_month(input logic [3:0] idx);
    logic [8:0] d;
    unique case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Days from 1970-01-01 to January 1st of year y (y at least 1601).
  function automatic longint days_to_jan1(input longint y);
    return 365 * (y - 1970) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 - 477;
  endfunction

endpackage

### src/cem_day_div.sv
// Pipelined split of a non-negative ms count into days and ms of day by reciprocal
// multiplication: an estimate, its remainder and one correction. Depends on cem_pkg.
module cem_day_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_v,
  input  logic [cem_pkg::DIV_XW-1:0]    x,
  input  cem_pkg::side_t                side_in,
  output logic                          out_v,
  output logic [cem_pkg::DIV_QW-1:0]    q,
  output logic [cem_pkg::DIV_RW-1:0]    r,
  output cem_pkg::side_t                side_out
);

  localparam int QW  = cem_pkg::DIV_QW;
  localparam int RW  = cem_pkg::DIV_RW;
  localparam int R0W = RW + 1;

  // A day is 2^10 * 84375 ms, so the low ten bits never reach the quotient. The estimate
  // uses the top 25 bits of the dividend and is at most one below the true quotient.
  localparam int unsigned ODD_D = cem_pkg::MS_PER_DAY >> 10;
  localparam logic [25:0] REC_M = 26'((64'd1 << 42) / ODD_D);
  localparam logic [R0W-1:0] D_R0 = R0W'(cem_pkg::MS_PER_DAY);

  logic [2:0]     v_r;
  logic [50:0]    est_p;
  logic [QW-1:0]  qe1_r, qe2_r, q3_r;
  logic [R0W-1:0] x1_r, qd, r0_nxt, r2_r;
  logic [RW-1:0]  r3_r;
  cem_pkg::side_t side1_r, side2_r, side3_r;

  always_comb begin
    est_p  = 51'(x[cem_pkg::DIV_XW-1:22]) * 51'(REC_M);
    // The remainder of the estimate is below two days, so its low bits are enough.
    qd     = R0W'(qe1_r) * D_R0;
    r0_nxt = x1_r - qd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qe1_r   <= est_p[30 +: QW];
      x1_r    <= x[R0W-1:0];
      side1_r <= side_in;

      qe2_r   <= qe1_r;
      r2_r    <= r0_nxt;
      side2_r <= side1_r;

      if (r2_r >= D_R0) begin
        q3_r <= qe2_r + QW'(1);
        r3_r <= RW'(r2_r - D_R0);
      end else begin
        q3_r <= qe2_r;
        r3_r <= r2_r[RW-1:0];
      end
      side3_r <= side2_r;
    end
  end

  assign out_v    = v_r[2];
  assign q        = q3_r;
  assign r        = r3_r;
  assign side_out = side3_r;

endmodule

### src/calendar_epoch_ms_converter_core.sv
// Top level of the calendar date / Unix epoch millisecond converter.
// Depends on cem_pkg and cem_day_div.
//
// Converts a clamped Gregorian UTC date-time to signed ms since 1970 (mode 0) or splits
// signed ms, saturated to the year range, into calendar fields (mode 1). The block is a
// fixed 20-stage pipeline: four stages of clamping and day arithmetic, three stages of
// the day divider (reciprocal estimate, remainder and one correction) and thirteen stages
// of civil-date arithmetic. It takes one item every cycle unless stalled; a stall on the
// result side holds the whole pipeline, so in_ready follows out_ready while a result
// waits.
module calendar_epoch_ms_converter_core #(
  parameter int YEAR_FIRST = 1900,
  parameter int YEAR_LAST  = 2099
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [11:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic [5:0]         in_day,
  input  logic [4:0]         in_hour,
  input  logic [5:0]         in_minute,
  input  logic [5:0]         in_second,
  input  logic signed [42:0] in_epoch_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [42:0] out_epoch_ms,
  output logic [11:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second,
  output logic [9:0]         out_milli
);

  localparam logic [11:0] MIN_Y = 12'(YEAR_FIRST);
  localparam logic [11:0] MAX_Y = 12'(YEAR_LAST);
  localparam longint LO_DAYS = cem_pkg::days_to_jan1(longint'(YEAR_FIRST));
  localparam longint HI_DAYS = cem_pkg::days_to_jan1(longint'(YEAR_LAST) + 1);
  localparam logic signed [47:0] LO_MS = 48'(LO_DAYS * cem_pkg::MS_PER_DAY);
  localparam logic signed [47:0] HI_MS = 48'(HI_DAYS * cem_pkg::MS_PER_DAY - 1);
  localparam logic [20:0] ZOFF = 21'(LO_DAYS + cem_pkg::CIVIL_SHIFT);
  localparam logic signed [27:0] MSD_S = 28'(cem_pkg::MS_PER_DAY);

  // Constant division by multiplication with a rounded-up reciprocal: for an input of W
  // bits and shift W + clog2(D) + 1 the floor is exact over the whole input range.
  localparam int Y100_S = 12 + $clog2(100) + 1;
  localparam logic [14:0] Y100_M = 15'((64'd1 << Y100_S) / 100 + 64'd1);
  localparam int HR_S = 27 + $clog2(cem_pkg::MS_PER_HOUR) + 1;
  localparam logic [29:0] HR_M = 30'((64'd1 << HR_S) / cem_pkg::MS_PER_HOUR + 64'd1);
  localparam int MT_S = 27 + $clog2(cem_pkg::MS_PER_MIN) + 1;
  localparam logic [29:0] MT_M = 30'((64'd1 << MT_S) / cem_pkg::MS_PER_MIN + 64'd1);
  localparam int ST_S = 27 + $clog2(cem_pkg::MS_PER_SEC) + 1;
  localparam logic [29:0] ST_M = 30'((64'd1 << ST_S) / cem_pkg::MS_PER_SEC + 64'd1);
  localparam int ERA_S = 21 + $clog2(cem_pkg::DAYS_PER_ERA) + 1;
  localparam logic [23:0] ERA_M = 24'((64'd1 << ERA_S) / cem_pkg::DAYS_PER_ERA + 64'd1);
  localparam int A_S = 18 + $clog2(1460) + 1;
  localparam logic [20:0] A_M = 21'((64'd1 << A_S) / 1460 + 64'd1);
  localparam int B_S = 18 + $clog2(36524) + 1;
  localparam logic [20:0] B_M = 21'((64'd1 << B_S) / 36524 + 64'd1);
  localparam int C_S = 18 + $clog2(146096) + 1;
  localparam logic [20:0] C_M = 21'((64'd1 << C_S) / 146096 + 64'd1);
  localparam int YOE_S = 18 + $clog2(365) + 1;
  localparam logic [20:0] YOE_M = 21'((64'd1 << YOE_S) / 365 + 64'd1);
  localparam int YC_S = 9 + $clog2(100) + 1;
  localparam logic [11:0] YC_M = 12'((64'd1 << YC_S) / 100 + 64'd1);
  localparam int MP_S = 11 + $clog2(153) + 1;
  localparam logic [13:0] MP_M = 14'((64'd1 << MP_S) / 153 + 64'd1);
  localparam int K5_S = 11 + $clog2(5) + 1;
  localparam logic [13:0] K5_M = 14'((64'd1 << K5_S) / 5 + 64'd1);

  typedef struct packed {
    logic        mode;
    logic [42:0] ms0;
    logic [4:0]  hr;
    logic [5:0]  mn;
    logic [5:0]  sc;
    logic [9:0]  ml;
  } pass_t;

  logic adv;
  logic dv_v;
  logic [3:0]  sv_r;
  logic [12:0] cv_r;

  assign adv      = !cv_r[12] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      cv_r <= '0;
    end else if (adv) begin
      sv_r <= {sv_r[2:0], in_valid};
      cv_r <= {cv_r[11:0], dv_v};
    end
  end

  // Stage 1: clamping and the year divisions.
  logic [11:0] y_c, ym1;
  logic [3:0]  mo_c;
  logic [4:0]  d_c, h_c;
  logic [5:0]  mn_c, s_c;
  logic [26:0] pa, pb;
  logic signed [47:0] mse, ms_c;

  always_comb begin
    y_c  = (in_year < MIN_Y) ? MIN_Y : ((in_year > MAX_Y) ? MAX_Y : in_year);
    mo_c = (in_month == 4'd0) ? 4'd1 : ((in_month > 4'd12) ? 4'd12 : in_month);
    d_c  = (in_day == 6'd0) ? 5'd1 : ((in_day > 6'd31) ? 5'd31 : in_day[4:0]);
    h_c  = (in_hour > 5'd23) ? 5'd23 : in_hour;
    mn_c = (in_minute > 6'd59) ? 6'd59 : in_minute;
    s_c  = (in_second > 6'd59) ? 6'd59 : in_second;
    ym1  = y_c - 12'd1;
    pa   = 27'(ym1) * 27'(Y100_M);
    pb   = 27'(y_c) * 27'(Y100_M);
    mse  = 48'(in_epoch_ms);
    ms_c = (mse < LO_MS) ? LO_MS : ((mse > HI_MS) ? HI_MS : mse);
  end

  logic        s1_mode_r;
  logic [11:0] s1_y_r;
  logic [3:0]  s1_mi_r;
  logic [4:0]  s1_d_r, s1_h_r;
  logic [5:0]  s1_mn_r, s1_s_r;
  logic [9:0]  s1_q4_r;
  logic [5:0]  s1_q100_r, s1_yq_r;
  logic signed [47:0] s1_ms_r;

  // Stage 2: day count and time of day.
  logic [11:0] ymod;
  logic        leap;
  logic signed [23:0] ys, days_nxt;
  logic [26:0] tod_nxt;
  logic [46:0] x_nxt;

  always_comb begin
    ymod = s1_y_r - 12'(s1_yq_r) * 12'd100;
    leap = (ymod == 12'd0) ? (s1_yq_r[1:0] == 2'd0) : (s1_y_r[1:0] == 2'd0);
    ys   = 24'(s1_y_r);
    days_nxt = 24'sd365 * (ys - 24'sd1970) + 24'(s1_q4_r) - 24'(s1_q100_r)
             + 24'(s1_q100_r[5:2]) - 24'sd477
             + 24'(cem_pkg::days_before_month(s1_mi_r))
             + 24'(leap && (s1_mi_r >= 4'd2)) + 24'(s1_d_r) - 24'sd1;
    tod_nxt = 27'(s1_h_r) * 27'(cem_pkg::MS_PER_HOUR)
            + 27'(s1_mn_r) * 27'(cem_pkg::MS_PER_MIN)
            + 27'(s1_s_r) * 27'(cem_pkg::MS_PER_SEC);
    x_nxt = 47'(s1_ms_r - LO_MS);
  end

  logic        s2_mode_r, s3_mode_r, s4_mode_r;
  logic signed [23:0] s2_days_r;
  logic [26:0] s2_tod_r, s3_tod_r;
  logic [46:0] s2_x_r, s3_x_r, s4_x_r;
  logic signed [47:0] s3_prod_r, s4_ms0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r <= in_mode;
      s1_y_r    <= y_c;
      s1_mi_r   <= mo_c - 4'd1;
      s1_d_r    <= d_c;
      s1_h_r    <= h_c;
      s1_mn_r   <= mn_c;
      s1_s_r    <= s_c;
      s1_q4_r   <= ym1[11:2];
      s1_q100_r <= pa[Y100_S +: 6];
      s1_yq_r   <= pb[Y100_S +: 6];
      s1_ms_r   <= ms_c;

      s2_mode_r <= s1_mode_r;
      s2_days_r <= days_nxt;
      s2_tod_r  <= tod_nxt;
      s2_x_r    <= x_nxt;

      s3_mode_r <= s2_mode_r;
      s3_prod_r <= s2_days_r * MSD_S;
      s3_tod_r  <= s2_tod_r;
      s3_x_r    <= s2_x_r;

      s4_mode_r <= s3_mode_r;
      s4_ms0_r  <= s3_prod_r + $signed(48'(s3_tod_r));
      s4_x_r    <= s3_x_r;
    end
  end

  logic [cem_pkg::DIV_QW-1:0] dv_q;
  logic [cem_pkg::DIV_RW-1:0] dv_r;
  cem_pkg::side_t dv_side, dv_side_in;

  assign dv_side_in.mode = s4_mode_r;
  assign dv_side_in.ms0  = s4_ms0_r[42:0];

  cem_day_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (sv_r[3]),
    .x        (s4_x_r),
    .side_in  (dv_side_in),
    .out_v    (dv_v),
    .q        (dv_q),
    .r        (dv_r),
    .side_out (dv_side)
  );

  // Civil date from the day number, days counted from 0000-03-01.
  logic [56:0] hr_p, mt_p, st_p;
  logic [44:0] era_p;
  logic [38:0] a_p, b_p, c_p, yoe_p;
  logic [20:0] yc_p;
  logic [24:0] mp_p, k5_p;

  logic [20:0] c1_z_r, c2_z_r;
  logic [26:0] c1_r_r;
  logic [4:0]  c1_hr_r;
  logic [10:0] c1_mt_r;
  logic [16:0] c1_st_r;
  cem_pkg::side_t c1_side_r;
  logic [3:0]  c2_era_r, c3_era_r, c4_era_r, c5_era_r, c6_era_r, c7_era_r;
  logic [17:0] c3_doe_r, c4_doe_r, c5_doe_r, c6_doe_r, c7_doe_r, c5_t_r;
  logic [6:0]  c4_a_r;
  logic [2:0]  c4_b_r;
  logic        c4_c_r;
  logic [8:0]  c6_yoe_r, c7_yoe_r;
  logic [17:0] c7_p365_r;
  logic [2:0]  c7_y100_r;
  logic [8:0]  c8_doy_r, c9_doy_r, c10_doy_r, c11_doy_r, c12_doy_r;
  logic [12:0] c8_yr_r, c9_yr_r, c10_yr_r, c11_yr_r, c12_yr_r;
  logic [10:0] c9_n_r, c11_k_r;
  logic [3:0]  c10_mp_r, c11_mp_r, c12_mp_r;
  logic [8:0]  c12_k5_r;
  pass_t c2_p_r, c3_p_r, c4_p_r, c5_p_r, c6_p_r, c7_p_r, c8_p_r, c9_p_r, c10_p_r,
         c11_p_r, c12_p_r;

  logic signed [42:0] out_epoch_ms_r;
  logic [11:0] out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r, out_hour_r;
  logic [5:0]  out_minute_r, out_second_r;
  logic [9:0]  out_milli_r;

  logic [4:0]  dd_nxt;
  logic [3:0]  mm_nxt;
  logic [12:0] yr_nxt;
  pass_t p_nxt;

  always_comb begin
    hr_p  = 57'(dv_r) * 57'(HR_M);
    mt_p  = 57'(dv_r) * 57'(MT_M);
    st_p  = 57'(dv_r) * 57'(ST_M);
    era_p = 45'(c1_z_r) * 45'(ERA_M);
    a_p   = 39'(c3_doe_r) * 39'(A_M);
    b_p   = 39'(c3_doe_r) * 39'(B_M);
    c_p   = 39'(c3_doe_r) * 39'(C_M);
    yoe_p = 39'(c5_t_r) * 39'(YOE_M);
    yc_p  = 21'(c6_yoe_r) * 21'(YC_M);
    mp_p  = 25'(c9_n_r) * 25'(MP_M);
    k5_p  = 25'(c11_k_r) * 25'(K5_M);

    p_nxt.mode = c1_side_r.mode;
    p_nxt.ms0  = c1_side_r.ms0;
    p_nxt.hr   = c1_hr_r;
    p_nxt.mn   = 6'(c1_mt_r - 11'(c1_hr_r) * 11'd60);
    p_nxt.sc   = 6'(c1_st_r - 17'(c1_mt_r) * 17'd60);
    p_nxt.ml   = 10'(c1_r_r - 27'(c1_st_r) * 27'd1000);

    dd_nxt = 5'(c12_doy_r - c12_k5_r + 9'd1);
    mm_nxt = (c12_mp_r < 4'd10) ? c12_mp_r + 4'd3 : c12_mp_r - 4'd9;
    yr_nxt = c12_yr_r + 13'(mm_nxt <= 4'd2);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_z_r    <= 21'(dv_q) + ZOFF;
      c1_r_r    <= dv_r;
      c1_hr_r   <= hr_p[HR_S +: 5];
      c1_mt_r   <= mt_p[MT_S +: 11];
      c1_st_r   <= st_p[ST_S +: 17];
      c1_side_r <= dv_side;

      c2_z_r    <= c1_z_r;
      c2_era_r  <= era_p[ERA_S +: 4];
      c2_p_r    <= p_nxt;

      c3_doe_r  <= 18'(c2_z_r - 21'(c2_era_r) * 21'(cem_pkg::DAYS_PER_ERA));
      c3_era_r  <= c2_era_r;
      c3_p_r    <= c2_p_r;

      c4_a_r    <= a_p[A_S +: 7];
      c4_b_r    <= b_p[B_S +: 3];
      c4_c_r    <= c_p[C_S];
      c4_doe_r  <= c3_doe_r;
      c4_era_r  <= c3_era_r;
      c4_p_r    <= c3_p_r;

      c5_t_r    <= c4_doe_r - 18'(c4_a_r) + 18'(c4_b_r) - 18'(c4_c_r);
      c5_doe_r  <= c4_doe_r;
      c5_era_r  <= c4_era_r;
      c5_p_r    <= c4_p_r;

      c6_yoe_r  <= yoe_p[YOE_S +: 9];
      c6_doe_r  <= c5_doe_r;
      c6_era_r  <= c5_era_r;
      c6_p_r    <= c5_p_r;

      c7_p365_r <= 18'(c6_yoe_r) * 18'd365;
      c7_y100_r <= yc_p[YC_S +: 3];
      c7_yoe_r  <= c6_yoe_r;
      c7_doe_r  <= c6_doe_r;
      c7_era_r  <= c6_era_r;
      c7_p_r    <= c6_p_r;

      c8_doy_r  <= 9'(c7_doe_r - (c7_p365_r + 18'(c7_yoe_r[8:2]) - 18'(c7_y100_r)));
      c8_yr_r   <= 13'(c7_yoe_r) + 13'(c7_era_r) * 13'd400;
      c8_p_r    <= c7_p_r;

      c9_n_r    <= 11'(c8_doy_r) * 11'd5 + 11'd2;
      c9_doy_r  <= c8_doy_r;
      c9_yr_r   <= c8_yr_r;
      c9_p_r    <= c8_p_r;

      c10_mp_r  <= mp_p[MP_S +: 4];
      c10_doy_r <= c9_doy_r;
      c10_yr_r  <= c9_yr_r;
      c10_p_r   <= c9_p_r;

      c11_k_r   <= 11'(c10_mp_r) * 11'd153 + 11'd2;
      c11_mp_r  <= c10_mp_r;
      c11_doy_r <= c10_doy_r;
      c11_yr_r  <= c10_yr_r;
      c11_p_r   <= c10_p_r;

      c12_k5_r  <= k5_p[K5_S +: 9];
      c12_mp_r  <= c11_mp_r;
      c12_doy_r <= c11_doy_r;
      c12_yr_r  <= c11_yr_r;
      c12_p_r   <= c11_p_r;

      // Fields that do not belong to the item's direction read as zero.
      if (c12_p_r.mode) begin
        out_epoch_ms_r <= '0;
        out_year_r     <= yr_nxt[11:0];
        out_month_r    <= mm_nxt;
        out_day_r      <= dd_nxt;
        out_hour_r     <= c12_p_r.hr;
        out_minute_r   <= c12_p_r.mn;
        out_second_r   <= c12_p_r.sc;
        out_milli_r    <= c12_p_r.ml;
      end else begin
        out_epoch_ms_r <= $signed(c12_p_r.ms0);
        out_year_r     <= '0;
        out_month_r    <= '0;
        out_day_r      <= '0;
        out_hour_r     <= '0;
        out_minute_r   <= '0;
        out_second_r   <= '0;
        out_milli_r    <= '0;
      end
    end
  end

  assign out_valid    = cv_r[12];
  assign out_epoch_ms = out_epoch_ms_r;
  assign out_year     = out_year_r;
  assign out_month    = out_month_r;
  assign out_day      = out_day_r;
  assign out_hour     = out_hour_r;
  assign out_minute   = out_minute_r;
  assign out_second   = out_second_r;
  assign out_milli    = out_milli_r;

endmodule
